// ===== rtl/gkt_pkg.sv =====
// shared types and constants for the gradient to k-space trajectory block
`default_nettype none
package gkt_pkg;

	// configuration port shape
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPSAMPLE = 8'd1;

	// field widths
	localparam int GRAD_W = 16;
	localparam int GAIN_W = 32;
	localparam int ACC_W  = 32;
	localparam int PROD_W = 48;
	localparam int WGT_W  = 48;
	localparam int REPS_W = 7;

	// defaults for the top level parameters
	localparam int DEF_MAX_UPSAMPLE = 64;
	localparam int DEF_QUEUE_DEPTH  = 2;

	// one classified gradient sample, as it sits in the queue
	typedef struct packed {
		logic signed [PROD_W-1:0] prod_x;
		logic signed [PROD_W-1:0] prod_y;
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic                     start;
		logic [REPS_W-1:0]        reps;
	} gkt_item_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} gkt_qstat_t;

endpackage
`default_nettype wire

// ===== rtl/gradient_to_kspace_trajectory.sv =====
// Gradient to k-space trajectory with density weights, top level.
//
// Input channel (in_valid / in_stall) takes one 2-D gradient sample per beat
// with a start_of_readout flag that zeroes the k-space accumulators first.
// Output channel (out_valid / out_stall) gives upsample_factor beats per
// sample: kx, ky, weight = |gx*kx + gy*ky| and last_of_run on the final one.
// Config port: cfg_we with cfg_index 0 = gain (Q0.32), 1 = upsample_factor
// (low 7 bits kept); factor 0 acts as 1, above MAX_UPSAMPLE it acts as MAX_UPSAMPLE.
// Path of the first result: gain multiply into the queue, load, accumulate,
// weight products, weight sum and output.
// Throughput: one result per cycle while out_stall does not hold the output,
// set by the single accumulate step of the back end sequencer.
// Samples follow each other with no gap while the queue holds work.
// The queue lets the front keep taking samples while the back is repeating.
// Out_stall freezes the whole back pipeline while the output holds a result;
// once the queue and capture stage fill, in_stall rises.
// Reset: accumulators zero, gain 0, upsample_factor 1, queue empty.
`default_nettype none
module gradient_to_kspace_trajectory import gkt_pkg::*; #(
	parameter int MAX_UPSAMPLE = DEF_MAX_UPSAMPLE,
	parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [GRAD_W-1:0] grad_x,
	input  wire logic signed [GRAD_W-1:0] grad_y,
	input  wire logic                     start_of_readout,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [ACC_W-1:0]       kx,
	output logic signed [ACC_W-1:0]       ky,
	output logic [WGT_W-1:0]              weight,
	output logic                          last_of_run
);

	gkt_item_t  w_item;
	gkt_item_t  head;
	gkt_qstat_t q_stat;
	logic       push;
	logic       pop;

	// front end
	gkt_front #(
		.MAX_UPSAMPLE(MAX_UPSAMPLE)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.grad_x           (grad_x),
		.grad_y           (grad_y),
		.start_of_readout (start_of_readout),
		.q_stat           (q_stat),
		.push             (push),
		.item             (w_item)
	);

	// decoupling queue
	gkt_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (w_item),
		.pop    (pop),
		.rdata  (head),
		.stat   (q_stat)
	);

	// back end
	gkt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kx          (kx),
		.ky          (ky),
		.weight      (weight),
		.last_of_run (last_of_run)
	);

`ifndef SYNTH
	// front never pushes into a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

	// back never pops an empty queue
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// a full queue with a stalled back end holds off the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(in_stall && !pop) |=> in_stall)
		else $error("input not stalled behind a full queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/gkt_front.sv =====
// front end: config registers, input capture, repeat count and gradient times gain
`default_nettype none
module gkt_front import gkt_pkg::*; #(
	parameter int MAX_UPSAMPLE = DEF_MAX_UPSAMPLE
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [GRAD_W-1:0] grad_x,
	input  wire logic signed [GRAD_W-1:0] grad_y,
	input  wire logic                    start_of_readout,
	input  wire gkt_qstat_t              q_stat,
	output logic                         push,
	output gkt_item_t                    item
);

	localparam logic [REPS_W-1:0] MAX_REPS = REPS_W'(MAX_UPSAMPLE);

	logic [GAIN_W-1:0]        gain_q;
	logic [REPS_W-1:0]        factor_q;
	logic                     valid_s1;
	logic signed [GRAD_W-1:0] gx_s1;
	logic signed [GRAD_W-1:0] gy_s1;
	logic                     start_s1;
	logic [REPS_W-1:0]        reps_s1;
	logic [REPS_W-1:0]        reps;
	logic                     accept;
	logic signed [PROD_W:0]   full_x;
	logic signed [PROD_W:0]   full_y;
	logic signed [GAIN_W:0]   gain_s;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= '0;
			factor_q <= REPS_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_GAIN) begin
				gain_q <= cfg_data[GAIN_W-1:0];
			end else if (cfg_index == REG_UPSAMPLE) begin
				factor_q <= cfg_data[REPS_W-1:0];
			end
		end
	end

	// clamp the repeat count to one through the maximum
	always_comb begin
		if (factor_q == '0) begin
			reps = REPS_W'(1);
		end else if (factor_q > MAX_REPS) begin
			reps = MAX_REPS;
		end else begin
			reps = factor_q;
		end
	end

	// handshake: hold the capture stage while the queue is full
	assign push     = valid_s1 && !q_stat.full;
	assign in_stall = valid_s1 && q_stat.full;
	assign accept   = in_valid && !in_stall;

	// capture stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gx_s1    <= grad_x;
			gy_s1    <= grad_y;
			start_s1 <= start_of_readout;
			reps_s1  <= reps;
		end
	end

	// signed gradient times unsigned gain, registered in the queue
	assign gain_s = $signed({1'b0, gain_q});
	assign full_x = gx_s1 * gain_s;
	assign full_y = gy_s1 * gain_s;

	always_comb begin
		item.prod_x = full_x[PROD_W-1:0];
		item.prod_y = full_y[PROD_W-1:0];
		item.gx     = gx_s1;
		item.gy     = gy_s1;
		item.start  = start_s1;
		item.reps   = reps_s1;
	end

endmodule
`default_nettype wire

// ===== rtl/gkt_queue.sv =====
// short queue between the front and the back end
`default_nettype none
module gkt_queue import gkt_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire gkt_item_t wdata,
	input  wire logic      pop,
	output gkt_item_t      rdata,
	output gkt_qstat_t     stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	gkt_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gkt_back.sv =====
// back end: repetition sequencer, saturating accumulators and weight pipeline
`default_nettype none
module gkt_back import gkt_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gkt_item_t            head,
	input  wire gkt_qstat_t           q_stat,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [ACC_W-1:0]   kx,
	output logic signed [ACC_W-1:0]   ky,
	output logic [WGT_W-1:0]          weight,
	output logic                      last_of_run
);

	gkt_item_t                cur_q;
	logic                     cur_valid_q;
	logic [REPS_W-1:0]        cnt_q;
	logic signed [ACC_W-1:0]  acc_x_q;
	logic signed [ACC_W-1:0]  acc_y_q;
	logic                     adv;
	logic                     issue;
	logic                     is_last;
	logic                     take;
	logic signed [ACC_W-1:0]  base_x;
	logic signed [ACC_W-1:0]  base_y;
	logic signed [ACC_W-1:0]  new_x;
	logic signed [ACC_W-1:0]  new_y;

	logic                     valid_s1;
	logic signed [ACC_W-1:0]  kx_s1;
	logic signed [ACC_W-1:0]  ky_s1;
	logic signed [GRAD_W-1:0] gx_s1;
	logic signed [GRAD_W-1:0] gy_s1;
	logic                     last_s1;
	logic signed [PROD_W-1:0] px;
	logic signed [PROD_W-1:0] py;

	logic                     valid_s2;
	logic signed [PROD_W-1:0] px_s2;
	logic signed [PROD_W-1:0] py_s2;
	logic signed [ACC_W-1:0]  kx_s2;
	logic signed [ACC_W-1:0]  ky_s2;
	logic                     last_s2;
	logic signed [PROD_W:0]   dot;
	logic [PROD_W:0]          mag;

	logic                     out_valid_q;
	logic signed [ACC_W-1:0]  kx_q;
	logic signed [ACC_W-1:0]  ky_q;
	logic [WGT_W-1:0]         weight_q;
	logic                     last_q;

	// floor of product over 2^16 added to the accumulator, clipped to 32 bits
	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0]  a,
		input logic signed [PROD_W-1:0] p
	);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {p[PROD_W-1], p[PROD_W-1:PROD_W-ACC_W]};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return s[ACC_W-1:0];
	endfunction

	// the whole pipeline moves when the output register is free or taken
	assign adv     = !out_valid_q || !out_stall;
	assign issue   = cur_valid_q && adv;
	assign is_last = (REPS_W'(cnt_q + 1'b1) == cur_q.reps);
	assign take    = !cur_valid_q || (issue && is_last);
	assign pop     = take && !q_stat.empty;

	// start of readout clears the accumulators ahead of the first repetition
	assign base_x = (cnt_q == '0 && cur_q.start) ? '0 : acc_x_q;
	assign base_y = (cnt_q == '0 && cur_q.start) ? '0 : acc_y_q;
	assign new_x  = sat_add(base_x, cur_q.prod_x);
	assign new_y  = sat_add(base_y, cur_q.prod_y);

	// repetition sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cnt_q       <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
		end else begin
			if (issue) begin
				acc_x_q <= new_x;
				acc_y_q <= new_y;
			end
			if (take) begin
				cur_valid_q <= !q_stat.empty;
				cnt_q       <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= issue;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// gradient times position products, then sum and magnitude
	assign px  = gx_s1 * kx_s1;
	assign py  = gy_s1 * ky_s1;
	assign dot = {px_s2[PROD_W-1], px_s2} + {py_s2[PROD_W-1], py_s2};
	assign mag = dot[PROD_W] ? -dot : dot;

	always_ff @(posedge clk) begin
		if (adv) begin
			kx_s1    <= new_x;
			ky_s1    <= new_y;
			gx_s1    <= cur_q.gx;
			gy_s1    <= cur_q.gy;
			last_s1  <= is_last;
			px_s2    <= px;
			py_s2    <= py;
			kx_s2    <= kx_s1;
			ky_s2    <= ky_s1;
			last_s2  <= last_s1;
			kx_q     <= kx_s2;
			ky_q     <= ky_s2;
			weight_q <= mag[WGT_W-1:0];
			last_q   <= last_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign kx          = kx_q;
	assign ky          = ky_q;
	assign weight      = weight_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire
